// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expands to one labelled concurrent assertion on clk_i / rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Types, constants and tables of the audio frame header decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mahd_pkg;

  // Header field positions and widths.
  localparam logic [31:0] SyncMask = 32'hffe0_0000;
  localparam int unsigned NumW     = 27;  // coefficient times bitrate
  localparam int unsigned SrW      = 16;
  localparam int unsigned BrW      = 19;
  localparam int unsigned FsW      = 12;
  localparam int unsigned DurW     = 14;
  localparam int unsigned Num2W    = 32;  // frame size times 720000
  localparam logic [19:0] TicksPerByte = 20'd720000;  // 8 * 1000 * 90

  // Reserved and special field codes of the header.
  localparam logic [1:0] LayerReserved = 2'd0;
  localparam logic [1:0] ModeMono      = 2'd3;
  localparam logic [1:0] SrReserved    = 2'd3;
  localparam logic [3:0] BrBad         = 4'd15;

  // Side information that travels along the cell chain.
  typedef struct packed {
    logic            valid;
    logic [1:0]      channels;
    logic [SrW-1:0]  sample_rate;
    logic [BrW-1:0]  bit_rate;
    logic            pad;
    logic            layer1;
    logic [FsW-1:0]  frame_size;
  } info_t;

  // Base sampling rates in Hz, indexed by the sampling-rate field.
  function automatic logic [SrW-1:0] base_rate(input logic [1:0] idx);
    logic [SrW-1:0] r;
    unique case (idx)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Frame size coefficient by low-rate flag and layer index.
  function automatic logic [7:0] size_coef(input logic lsf, input logic [1:0] li);
    logic [7:0] c;
    unique case (li)
      2'd0:    c = 8'd12;
      2'd1:    c = 8'd144;
      2'd2:    c = lsf ? 8'd72 : 8'd144;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Bitrate tables in bit/s; index 15 is unused.
  localparam logic [BrW-1:0] BpsHi [3][16] = '{
    '{19'd0, 19'd32000, 19'd64000, 19'd96000, 19'd128000, 19'd160000, 19'd192000,
      19'd224000, 19'd256000, 19'd288000, 19'd320000, 19'd352000, 19'd384000,
      19'd416000, 19'd448000, 19'd0},
    '{19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
      19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000, 19'd256000,
      19'd320000, 19'd384000, 19'd0},
    '{19'd0, 19'd32000, 19'd40000, 19'd48000, 19'd56000, 19'd64000, 19'd80000,
      19'd96000, 19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000,
      19'd256000, 19'd320000, 19'd0}
  };

  localparam logic [BrW-1:0] BpsLo [3][16] = '{
    '{19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
      19'd112000, 19'd128000, 19'd144000, 19'd160000, 19'd176000, 19'd192000,
      19'd224000, 19'd256000, 19'd0},
    '{19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
      19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
      19'd144000, 19'd160000, 19'd0},
    '{19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
      19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
      19'd144000, 19'd160000, 19'd0}
  };

endpackage

// ===== hw/rtl/mahd_decode.sv =====
// ----------------------------------------------------------------------------
// mahd_decode
// First stage: field checks, table look-ups and the frame size dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mahd_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [31:0]               header_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [mahd_pkg::NumW-1:0] num_o,
  output logic [mahd_pkg::SrW-1:0]  den_o,
  output mahd_pkg::info_t           info_o
);

  logic                      valid_q;
  logic [mahd_pkg::NumW-1:0] num_q, num_d;
  logic [mahd_pkg::SrW-1:0]  den_q, den_d;
  mahd_pkg::info_t           info_q, info_d;

  logic       lsf;
  logic [1:0] shift, layer_code, li, sri, mode;
  logic [3:0] bri;
  logic [mahd_pkg::BrW-1:0] br;
  logic [mahd_pkg::SrW-1:0] sr;
  logic       ok;

  // Field extraction and version decoding.
  always_comb begin
    layer_code = header_i[18:17];
    sri        = header_i[11:10];
    bri        = header_i[15:12];
    mode       = header_i[7:6];
    if (header_i[20]) begin
      lsf   = ~header_i[19];
      shift = {1'b0, ~header_i[19]};
    end else begin
      lsf   = 1'b1;
      shift = 2'd2;
    end
    li = 2'd3 - layer_code;
    sr = mahd_pkg::base_rate(sri) >> shift;
    br = lsf ? mahd_pkg::BpsLo[li][bri] : mahd_pkg::BpsHi[li][bri];
    ok = ((header_i & mahd_pkg::SyncMask) == mahd_pkg::SyncMask) &&
         (layer_code != mahd_pkg::LayerReserved) && (sri != mahd_pkg::SrReserved) &&
         (bri != mahd_pkg::BrBad) && (br != '0);
  end

  // Next payload; invalid headers divide zero by one.
  always_comb begin
    info_d = '0;
    num_d  = '0;
    den_d  = mahd_pkg::SrW'(1);
    if (ok) begin
      info_d.valid       = 1'b1;
      info_d.channels    = (mode == mahd_pkg::ModeMono) ? 2'd1 : 2'd2;
      info_d.sample_rate = sr;
      info_d.bit_rate    = br;
      info_d.pad         = header_i[9];
      info_d.layer1      = (li == 2'd0);
      num_d = mahd_pkg::NumW'(mahd_pkg::size_coef(lsf, li) * br);
      den_d = sr;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      info_q <= info_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign info_o  = info_q;

endmodule

// ===== hw/rtl/mahd_div_cell.sv =====
// ----------------------------------------------------------------------------
// mahd_div_cell
// One restoring division cell: settles one quotient bit per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mahd_div_cell #(
  parameter int unsigned NW  = 32,
  parameter int unsigned DW  = 19,
  parameter int unsigned QW  = 14,
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [NW-1:0]   rem_i,
  input  logic [DW-1:0]   den_i,
  input  logic [QW-1:0]   quo_i,
  input  mahd_pkg::info_t info_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [NW-1:0]   rem_o,
  output logic [DW-1:0]   den_o,
  output logic [QW-1:0]   quo_o,
  output mahd_pkg::info_t info_o
);

  localparam int unsigned XW = NW + DW;

  logic                 valid_q;
  logic [NW-1:0]        rem_q, rem_d;
  logic [DW-1:0]        den_q;
  logic [QW-1:0]        quo_q, quo_d;
  mahd_pkg::info_t      info_q;
  logic [XW-1:0]        rem_x, sub_x, diff_x;
  logic                 ge;

  // Trial subtraction of the divisor shifted to this bit.
  always_comb begin
    rem_x  = XW'(rem_i);
    sub_x  = XW'(den_i) << BIT;
    ge     = rem_x >= sub_x;
    diff_x = rem_x - sub_x;
    rem_d  = ge ? NW'(diff_x) : rem_i;
    quo_d  = quo_i;
    quo_d[BIT] = ge;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      info_q <= info_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign info_o  = info_q;

endmodule

// ===== hw/rtl/mahd_frame.sv =====
// ----------------------------------------------------------------------------
// mahd_frame
// Middle stage: frame size from the first quotient and the duration dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mahd_frame (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [mahd_pkg::FsW-1:0]   quo_i,
  input  mahd_pkg::info_t            info_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [mahd_pkg::Num2W-1:0] num_o,
  output logic [mahd_pkg::BrW-1:0]   den_o,
  output mahd_pkg::info_t            info_o
);

  logic                       valid_q;
  logic [mahd_pkg::Num2W-1:0] num_q, num_d;
  logic [mahd_pkg::BrW-1:0]   den_q, den_d;
  mahd_pkg::info_t            info_q, info_d;
  logic [mahd_pkg::FsW-1:0]   slots;

  // Add the padding slot, scale to bytes, form the tick dividend.
  always_comb begin
    slots  = quo_i + mahd_pkg::FsW'(info_i.pad);
    info_d = info_i;
    info_d.frame_size = info_i.layer1 ? (slots << 2) : slots;
    num_d  = mahd_pkg::Num2W'(info_d.frame_size * mahd_pkg::TicksPerByte);
    den_d  = info_i.valid ? info_i.bit_rate : mahd_pkg::BrW'(1);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      info_q <= info_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign info_o  = info_q;

endmodule

// ===== hw/rtl/mpeg_audio_header_decoder.sv =====
// Throughput: one header per cycle while the output is not stalled; the chain holds up to 28 headers in flight.
// The chain is the decode stage, the 12 frame-size division cells, the frame stage and the 14 duration cells.
// Each cell stalls only when it is full and its neighbour is full and stalled.
// Reset clears every stage valid flag; payload registers are not reset.
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// Audio frame header decoder built as a chain of restoring division cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpeg_audio_header_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // header_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // valid_res, channels, sample_rate, bit_rate, frame_size, duration_ticks
  output logic [63:0] m_axis_tdata_o
);

  `include "assert_macros.svh"

  localparam int unsigned N1 = mahd_pkg::NumW;
  localparam int unsigned D1 = mahd_pkg::SrW;
  localparam int unsigned Q1 = mahd_pkg::FsW;
  localparam int unsigned N2 = mahd_pkg::Num2W;
  localparam int unsigned D2 = mahd_pkg::BrW;
  localparam int unsigned Q2 = mahd_pkg::DurW;

  logic            v1 [Q1+1];
  logic            r1 [Q1+1];
  logic [N1-1:0]   rem1 [Q1+1];
  logic [D1-1:0]   den1 [Q1+1];
  logic [Q1-1:0]   quo1 [Q1+1];
  mahd_pkg::info_t inf1 [Q1+1];

  logic            v2 [Q2+1];
  logic            r2 [Q2+1];
  logic [N2-1:0]   rem2 [Q2+1];
  logic [D2-1:0]   den2 [Q2+1];
  logic [Q2-1:0]   quo2 [Q2+1];
  mahd_pkg::info_t inf2 [Q2+1];

  mahd_pkg::info_t fin;

  // Header checks and table look-ups.
  mahd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .header_i (s_axis_tdata_i),
    .valid_o  (v1[0]),
    .ready_i  (r1[0]),
    .num_o    (rem1[0]),
    .den_o    (den1[0]),
    .info_o   (inf1[0])
  );
  assign quo1[0] = '0;

  // Frame size division, most significant quotient bit first.
  for (genvar k = 0; k < Q1; k++) begin : g_div1
    mahd_div_cell #(.NW(N1), .DW(D1), .QW(Q1), .BIT(Q1-1-k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v1[k]),
      .ready_o (r1[k]),
      .rem_i   (rem1[k]),
      .den_i   (den1[k]),
      .quo_i   (quo1[k]),
      .info_i  (inf1[k]),
      .valid_o (v1[k+1]),
      .ready_i (r1[k+1]),
      .rem_o   (rem1[k+1]),
      .den_o   (den1[k+1]),
      .quo_o   (quo1[k+1]),
      .info_o  (inf1[k+1])
    );
  end

  // Padding, slot size and the duration dividend.
  mahd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1[Q1]),
    .ready_o (r1[Q1]),
    .quo_i   (quo1[Q1]),
    .info_i  (inf1[Q1]),
    .valid_o (v2[0]),
    .ready_i (r2[0]),
    .num_o   (rem2[0]),
    .den_o   (den2[0]),
    .info_o  (inf2[0])
  );
  assign quo2[0] = '0;

  // Duration division by the bitrate.
  for (genvar k = 0; k < Q2; k++) begin : g_div2
    mahd_div_cell #(.NW(N2), .DW(D2), .QW(Q2), .BIT(Q2-1-k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v2[k]),
      .ready_o (r2[k]),
      .rem_i   (rem2[k]),
      .den_i   (den2[k]),
      .quo_i   (quo2[k]),
      .info_i  (inf2[k]),
      .valid_o (v2[k+1]),
      .ready_i (r2[k+1]),
      .rem_o   (rem2[k+1]),
      .den_o   (den2[k+1]),
      .quo_o   (quo2[k+1]),
      .info_o  (inf2[k+1])
    );
  end

  // The last cell is the output register; invalid headers read as zeros.
  assign fin             = inf2[Q2];
  assign m_axis_tvalid_o = v2[Q2];
  assign r2[Q2]          = m_axis_tready_i;
  assign m_axis_tdata_o  = fin.valid ?
    {quo2[Q2], fin.frame_size, fin.bit_rate, fin.sample_rate, fin.channels, 1'b1} :
    64'd0;

  // Consistency of a delivered result.
  `ASSERT_IMPLIES(a_valid_rates, m_axis_tvalid_o && m_axis_tdata_o[0],
                  m_axis_tdata_o[18:3] != '0 && m_axis_tdata_o[37:19] != '0,
                  "valid result with zero rate")
  `ASSERT_IMPLIES(a_valid_size, m_axis_tvalid_o && m_axis_tdata_o[0],
                  m_axis_tdata_o[49:38] != '0 && m_axis_tdata_o[2:1] != 2'd0,
                  "valid result with zero frame size or channels")
  `ASSERT_IMPLIES(a_stall_ready, m_axis_tvalid_o && !m_axis_tready_i,
                  !r2[Q2-1] || !v2[Q2-1] || v2[Q2],
                  "last cell accepted a beat while stalled")

endmodule
